// ===== hdl/mthk_pkg.sv =====
// ----------------------------------------------------------------------------
// mthk_pkg: shared types and constants
// slot state record, action codes and register indexes used by the
// multi-tap / hold key detector and its cells
// ----------------------------------------------------------------------------
package mthk_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int TIME_BITS = 16;
    localparam int CODE_W    = 16;
    localparam int IDX_W     = 3;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int TAPS_MAX  = 3;

    typedef enum logic [1:0] {
        ACT_TAP    = 2'd0,
        ACT_DOUBLE = 2'd1,
        ACT_TRIPLE = 2'd2,
        ACT_HOLD   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CODES_LOW  = 3'd0,
        REG_CODES_HIGH = 3'd1,
        REG_ACTIONS    = 3'd2,
        REG_SLOTS      = 3'd3,
        REG_TERM       = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic                 active;
        logic                 pressed;
        logic                 hold_done;
        logic [1:0]           taps;
        logic [TIME_BITS-1:0] stamp;
    } slot_state_t;

    typedef struct packed {
        logic    fire;
        action_t code;
    } slot_action_t;

    typedef struct packed {
        logic                 is_tick;
        logic [CODE_W-1:0]    key_code;
        logic                 key_down;
        logic [TIME_BITS-1:0] time_now;
    } item_t;

endpackage

// ===== hdl/mthk_cell.sv =====
// ----------------------------------------------------------------------------
// mthk_cell: one slot's state in the ring
// holds a slot record and takes its neighbor's record on each walk step
// ----------------------------------------------------------------------------
module mthk_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  mthk_pkg::slot_state_t st_in,
    output mthk_pkg::slot_state_t st_out
);

    mthk_pkg::slot_state_t st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (shift_en)
        begin
            st_reg <= st_in;
        end
    end

    assign st_out = st_reg;

endmodule

// ===== hdl/mthk_slot_logic.sv =====
// ----------------------------------------------------------------------------
// mthk_slot_logic: slot update at the head of the ring
// applies a key event or a scan tick to the record leaving the head cell
// ----------------------------------------------------------------------------
module mthk_slot_logic (
    input  mthk_pkg::slot_state_t          st_in,
    input  mthk_pkg::item_t                item,
    input  logic                           in_range,
    input  logic                           matched,
    input  logic [mthk_pkg::CODE_W-1:0]    slot_code,
    input  logic [3:0]                     slot_mask,
    input  logic [mthk_pkg::TIME_BITS-1:0] term,
    output mthk_pkg::slot_state_t          st_out,
    output mthk_pkg::slot_action_t         act,
    output logic                           hit
);

    logic [mthk_pkg::TIME_BITS-1:0] elapsed;
    logic                           expired;
    logic [1:0]                     taps_inc;
    logic                           fin;
    mthk_pkg::action_t              fin_code;

    assign elapsed = item.time_now - st_in.stamp;
    assign expired = elapsed > term;
    assign hit     = !item.is_tick && in_range && !matched && (slot_code == item.key_code);
    assign taps_inc = (st_in.taps < 2'(mthk_pkg::TAPS_MAX)) ? st_in.taps + 2'd1 : st_in.taps;

    always_comb
    begin
        st_out   = st_in;
        act.fire = 1'b0;
        act.code = mthk_pkg::ACT_TAP;
        fin      = 1'b0;
        fin_code = mthk_pkg::ACT_TRIPLE;

        if (hit)
        begin
            if (item.key_down)
            begin
                if (!st_in.active)
                begin
                    st_out.active = 1'b1;
                    st_out.taps   = 2'd0;
                end
                st_out.pressed   = 1'b1;
                st_out.hold_done = 1'b0;
                st_out.stamp     = item.time_now;
            end
            else if (st_in.hold_done)
            begin
                st_out.active  = 1'b0;
                st_out.pressed = 1'b0;
            end
            else
            begin
                st_out.taps    = taps_inc;
                st_out.pressed = 1'b0;
                st_out.stamp   = item.time_now;
                // finalize at once when no more taps can change the action
                fin = (!slot_mask[mthk_pkg::ACT_DOUBLE] && !slot_mask[mthk_pkg::ACT_TRIPLE])
                   || (!slot_mask[mthk_pkg::ACT_TRIPLE] && taps_inc == 2'd2)
                   || (taps_inc == 2'(mthk_pkg::TAPS_MAX));
            end
        end
        else if (item.is_tick && in_range && st_in.active)
        begin
            if (st_in.pressed && !st_in.hold_done && expired)
            begin
                act.fire         = slot_mask[mthk_pkg::ACT_HOLD];
                act.code         = mthk_pkg::ACT_HOLD;
                st_out.hold_done = 1'b1;
            end
            if (!st_in.pressed && !st_in.hold_done && expired)
            begin
                fin = 1'b1;
            end
            if (st_in.hold_done && !st_in.pressed)
            begin
                st_out.active = 1'b0;
            end
        end

        if (fin)
        begin
            case (st_out.taps)
                2'd1:    fin_code = mthk_pkg::ACT_TAP;
                2'd2:    fin_code = mthk_pkg::ACT_DOUBLE;
                default: fin_code = mthk_pkg::ACT_TRIPLE;
            endcase
            act.fire      = slot_mask[fin_code];
            act.code      = fin_code;
            st_out.active = 1'b0;
        end
    end

endmodule

// ===== hdl/multi_tap_hold_key_detector.sv =====
// ----------------------------------------------------------------------------
// multi_tap_hold_key_detector: tap / double / triple / hold key detector
// slot records circulate through a ring of cells; each walk step updates the
// record at the head and can produce one action item
// ----------------------------------------------------------------------------
// requests: a new item is taken only in idle, so each walk over the ring of
//   slot cells and the flush state end before the next accept; the walk can
//   hold while the result register is stalled
// reset: asynchronous, clears all slot state, codes, masks and slot count,
//   tapping term returns to 200
module multi_tap_hold_key_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mthk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mthk_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic                              req_type,
    input  logic [mthk_pkg::CODE_W-1:0]       key_code,
    input  logic                              key_down,
    input  logic [mthk_pkg::TIME_BITS-1:0]    time_now,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic                              pass_through,
    output logic                              action_valid,
    output logic [mthk_pkg::IDX_W-1:0]        slot_index,
    output logic [1:0]                        action_code,
    output logic                              last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } state_t;

    state_t state_reg;

    logic [mthk_pkg::CFG_W-1:0]     codes_low_reg;
    logic [mthk_pkg::CFG_W-1:0]     codes_high_reg;
    logic [31:0]                    actions_reg;
    logic [3:0]                     slots_reg;
    logic [mthk_pkg::TIME_BITS-1:0] term_reg;

    mthk_pkg::item_t                item_reg;
    logic [mthk_pkg::STEP_W-1:0]    step_reg;
    logic                           matched_reg;
    logic                           pend_vld_reg;
    logic [mthk_pkg::IDX_W-1:0]     pend_idx_reg;
    mthk_pkg::action_t              pend_code_reg;

    logic                           rsp_valid_reg;
    logic                           pass_reg;
    logic                           act_valid_reg;
    logic [mthk_pkg::IDX_W-1:0]     idx_reg;
    mthk_pkg::action_t              code_reg;
    logic                           last_reg;

    mthk_pkg::slot_state_t          ring [mthk_pkg::NUM_SLOTS];
    mthk_pkg::slot_state_t          head_next;
    mthk_pkg::slot_action_t         head_act;
    logic                           head_hit;
    logic                           shift_en;

    logic [3:0]                     count;
    logic                           in_range;
    logic [mthk_pkg::IDX_W-1:0]     cur_idx;
    logic [2*mthk_pkg::CFG_W-1:0]   all_codes;
    logic [mthk_pkg::CODE_W-1:0]    cur_code;
    logic [3:0]                     cur_mask;
    logic                           can_push;
    logic                           walk_ok;
    logic                           flush_need;
    logic                           push_rsp;

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == S_IDLE);

    assign count     = (slots_reg > 4'(mthk_pkg::NUM_SLOTS)) ? 4'(mthk_pkg::NUM_SLOTS) : slots_reg;
    assign cur_idx   = step_reg[mthk_pkg::IDX_W-1:0];
    assign in_range  = step_reg < count;
    assign all_codes = {codes_high_reg, codes_low_reg};
    assign cur_code  = all_codes[cur_idx*mthk_pkg::CODE_W +: mthk_pkg::CODE_W];
    assign cur_mask  = actions_reg[cur_idx*4 +: 4];

    assign can_push   = !rsp_valid_reg || rsp_ready;
    // a second action item can only move on once the result register frees up
    assign walk_ok    = !(head_act.fire && pend_vld_reg) || can_push;
    assign shift_en   = (state_reg == S_WALK) && walk_ok;
    assign flush_need = pend_vld_reg || (!item_reg.is_tick && !matched_reg);
    assign push_rsp   = ((state_reg == S_WALK) && walk_ok && head_act.fire && pend_vld_reg)
                     || ((state_reg == S_FLUSH) && flush_need && can_push);

    // ring of slot cells, head record feeds the update logic, result re-enters at the tail
    genvar g;
    generate
        for (g = 0; g < mthk_pkg::NUM_SLOTS; g++)
        begin : g_cell
            if (g == mthk_pkg::NUM_SLOTS - 1)
            begin : g_tail
                mthk_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .st_in    (head_next),
                    .st_out   (ring[g])
                );
            end
            else
            begin : g_body
                mthk_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .st_in    (ring[g+1]),
                    .st_out   (ring[g])
                );
            end
        end
    endgenerate

    mthk_slot_logic u_slot_logic (
        .st_in     (ring[0]),
        .item      (item_reg),
        .in_range  (in_range),
        .matched   (matched_reg),
        .slot_code (cur_code),
        .slot_mask (cur_mask),
        .term      (term_reg),
        .st_out    (head_next),
        .act       (head_act),
        .hit       (head_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_low_reg  <= '0;
            codes_high_reg <= '0;
            actions_reg    <= '0;
            slots_reg      <= '0;
            term_reg       <= mthk_pkg::TIME_BITS'(200);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mthk_pkg::REG_CODES_LOW:  codes_low_reg  <= cfg_data;
                mthk_pkg::REG_CODES_HIGH: codes_high_reg <= cfg_data;
                mthk_pkg::REG_ACTIONS:    actions_reg    <= cfg_data[31:0];
                mthk_pkg::REG_SLOTS:      slots_reg      <= cfg_data[3:0];
                mthk_pkg::REG_TERM:       term_reg       <= cfg_data[mthk_pkg::TIME_BITS-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            step_reg      <= '0;
            matched_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
            pend_idx_reg  <= '0;
            pend_code_reg <= mthk_pkg::ACT_TAP;
            rsp_valid_reg <= 1'b0;
            pass_reg      <= 1'b0;
            act_valid_reg <= 1'b0;
            idx_reg       <= '0;
            code_reg      <= mthk_pkg::ACT_TAP;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (push_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        item_reg.is_tick  <= req_type;
                        item_reg.key_code <= key_code;
                        item_reg.key_down <= key_down;
                        item_reg.time_now <= time_now;
                        step_reg          <= '0;
                        matched_reg       <= 1'b0;
                        pend_vld_reg      <= 1'b0;
                        state_reg         <= S_WALK;
                    end
                end

                S_WALK:
                begin
                    if (walk_ok)
                    begin
                        if (head_hit)
                        begin
                            matched_reg <= 1'b1;
                        end
                        if (head_act.fire)
                        begin
                            if (pend_vld_reg)
                            begin
                                pass_reg      <= 1'b0;
                                act_valid_reg <= 1'b1;
                                idx_reg       <= pend_idx_reg;
                                code_reg      <= pend_code_reg;
                                last_reg      <= 1'b0;
                            end
                            pend_vld_reg  <= 1'b1;
                            pend_idx_reg  <= cur_idx;
                            pend_code_reg <= head_act.code;
                        end
                        if (step_reg == mthk_pkg::STEP_W'(mthk_pkg::NUM_SLOTS - 1))
                        begin
                            state_reg <= S_FLUSH;
                        end
                        step_reg <= step_reg + 1'b1;
                    end
                end

                S_FLUSH:
                begin
                    if (!flush_need)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (can_push)
                    begin
                        // unmatched key event leaves no pending action, only the pass item
                        pass_reg      <= !pend_vld_reg;
                        act_valid_reg <= pend_vld_reg;
                        idx_reg       <= pend_vld_reg ? pend_idx_reg : '0;
                        code_reg      <= pend_vld_reg ? pend_code_reg : mthk_pkg::ACT_TAP;
                        last_reg      <= 1'b1;
                        pend_vld_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign pass_through = pass_reg;
    assign action_valid = act_valid_reg;
    assign slot_index   = idx_reg;
    assign action_code  = code_reg;
    assign last         = last_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("item accepted while a walk was starting");

    a_no_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_vld_reg)
        else $error("pending action left over in idle");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (step_reg < mthk_pkg::STEP_W'(mthk_pkg::NUM_SLOTS)))
        else $error("walk step past last slot");

    a_push_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && head_act.fire && pend_vld_reg && !can_push) |=>
        (pend_vld_reg && $stable(step_reg)))
        else $error("walk moved while an action item was blocked");
`endif

endmodule
